FILE: design/rdq_pkg.sv
// shared constants and operation codes for the ring deque event queue
package rdq_pkg;

    localparam int QUEUE_DEPTH = 2048;
    localparam int EVENT_WIDTH = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);

    localparam int OP_W        = 3;
    localparam int POS_W       = 11;
    localparam int COUNT_W     = 11;
    localparam int PORT_EV_W   = 32;
    localparam int CMP_W       = (ADDR_W > POS_W) ? ADDR_W : POS_W;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
    localparam logic [OP_W-1:0] OP_POP    = 3'd4;

    typedef logic [ADDR_W-1:0] ptr_t;

endpackage

FILE: design/ring_deque_event_queue_top.sv
// ring deque event queue: pointer control around one event ram
//
// usage
//   input channel (in_valid/in_ready) carries one request: op, position and
//   event_in. ops are clear, append at back, insert at front, peek at an
//   index from the front and pop front. the buffer holds up to depth-1
//   events, one slot always stays empty.
//   output channel (out_valid/out_ready) returns exactly one result per
//   request: ok, event_out (zero unless a peek or pop succeeded) and count
//   after the request.
// timing
//   a request is decoded and the pointers updated in the cycle it is taken,
//   the ram is accessed at that edge and its registered read data lands in
//   the output register at the next edge, so out_valid rises once the result
//   has passed the ram read register and the output register. in_ready is
//   low while a request sits in the read stage, so requests do not overlap.
// reset
//   head and tail pointers go to zero, the queue is empty. event storage is
//   not cleared; only written entries are ever read.
// stall
//   while out_ready is low the finished result is held and in_ready stays
//   low, no request is dropped.
module ring_deque_event_queue_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rdq_pkg::OP_W-1:0]     op,
    input  logic [rdq_pkg::POS_W-1:0]    position,
    input  logic [rdq_pkg::PORT_EV_W-1:0] event_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         ok,
    output logic [rdq_pkg::PORT_EV_W-1:0] event_out,
    output logic [rdq_pkg::COUNT_W-1:0]  count
);

    rdq_pkg::ptr_t head_reg, head_next;
    rdq_pkg::ptr_t tail_reg, tail_next;

    logic                           s1_valid_reg;
    logic                           s1_ok_reg, s1_ok_next;
    logic                           s1_rd_reg, s1_rd_next;
    logic [rdq_pkg::COUNT_W-1:0]    s1_count_reg, s1_count_next;

    logic                           out_valid_reg;
    logic                           out_ok_reg;
    logic [rdq_pkg::PORT_EV_W-1:0]  out_event_reg;
    logic [rdq_pkg::COUNT_W-1:0]    out_count_reg;

    logic                           in_fire;
    logic                           ram_we;
    rdq_pkg::ptr_t                  ram_waddr;
    rdq_pkg::ptr_t                  ram_raddr;
    logic [rdq_pkg::EVENT_WIDTH-1:0] ram_wdata;
    logic [rdq_pkg::EVENT_WIDTH-1:0] ram_rdata;

    rdq_pkg::ptr_t                  cur_count;
    rdq_pkg::ptr_t                  tail_inc;
    rdq_pkg::ptr_t                  head_dec;
    rdq_pkg::ptr_t                  head_inc;

    assign in_ready = !s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    assign cur_count = tail_reg - head_reg;
    assign tail_inc  = tail_reg + rdq_pkg::ADDR_W'(1);
    assign head_dec  = head_reg - rdq_pkg::ADDR_W'(1);
    assign head_inc  = head_reg + rdq_pkg::ADDR_W'(1);
    assign ram_wdata = rdq_pkg::EVENT_WIDTH'(event_in);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        s1_ok_next = 1'b0;
        s1_rd_next = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        ram_raddr  = head_reg;
        if (in_fire)
        begin
            case (op)
                rdq_pkg::OP_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    s1_ok_next = 1'b1;
                end
                rdq_pkg::OP_APPEND:
                begin
                    if (tail_inc != head_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = tail_reg;
                        tail_next  = tail_inc;
                        s1_ok_next = 1'b1;
                    end
                end
                rdq_pkg::OP_INSERT:
                begin
                    if (head_dec != tail_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = head_dec;
                        head_next  = head_dec;
                        s1_ok_next = 1'b1;
                    end
                end
                rdq_pkg::OP_PEEK:
                begin
                    ram_raddr = head_reg + rdq_pkg::ADDR_W'(position);
                    if (rdq_pkg::CMP_W'(position) < rdq_pkg::CMP_W'(cur_count))
                    begin
                        s1_ok_next = 1'b1;
                        s1_rd_next = 1'b1;
                    end
                end
                rdq_pkg::OP_POP:
                begin
                    if (head_reg != tail_reg)
                    begin
                        head_next  = head_inc;
                        s1_ok_next = 1'b1;
                        s1_rd_next = 1'b1;
                    end
                end
                default:
                begin
                    s1_ok_next = 1'b0;
                end
            endcase
        end
        s1_count_next = rdq_pkg::COUNT_W'(tail_next - head_next);
    end

    rdq_ram #(
        .WIDTH (rdq_pkg::EVENT_WIDTH),
        .DEPTH (rdq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            s1_valid_reg <= in_fire;
            if (s1_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_rd_reg    <= s1_rd_next;
            s1_count_reg <= s1_count_next;
        end
        if (s1_valid_reg)
        begin
            out_ok_reg    <= s1_ok_reg;
            out_count_reg <= s1_count_reg;
            out_event_reg <= s1_rd_reg ? rdq_pkg::PORT_EV_W'(ram_rdata) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign event_out = out_event_reg;
    assign count     = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("taken request did not reach the read stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> out_valid_reg)
        else $error("read stage result lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !in_ready)
        else $error("request taken while read data pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> out_event_reg == '0)
        else $error("failed request returned a nonzero event");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && op == rdq_pkg::OP_CLEAR |=> s1_ok_reg && s1_count_reg == '0)
        else $error("clear did not empty the queue");

endmodule

FILE: design/rdq_ram.sv
// generic single-clock ram, one write port, one registered read port
module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
